>>> rtl/audio_auto_dma_input_reader_core_defines.svh
// assertion macros for the auto dma input reader
`ifndef AUDIO_AUTO_DMA_INPUT_READER_CORE_DEFINES_SVH
`define AUDIO_AUTO_DMA_INPUT_READER_CORE_DEFINES_SVH

// antecedent holds, consequent holds at the next edge
`define AADIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("aadir check failed");

// antecedent holds, consequent holds at the same edge
`define AADIR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aadir check failed");

`endif

>>> rtl/aadir_pkg.sv
`timescale 1ns / 1ps
package aadir_pkg;

    localparam int STORE_AW = 10;
    localparam int BANK_AW  = STORE_AW - 1;
    localparam int BANK_DEPTH = 2 ** BANK_AW;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_CLAIM = 2'd2
    } t_mode;

    localparam logic [1:0] CFG_CORE_SELECT = 2'd0;
    localparam logic [1:0] CFG_DMA_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_PLAY_MODE   = 2'd2;

    localparam int PM_MUTE1 = 1;
    localparam int PM_WIDE0 = 2;
    localparam int PM_CDDA1 = 3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         buffer_index;
        logic signed [15:0] buffer_value;
        logic [19:0]        data_left;
        logic [8:0]         write_position;
    } t_item;

    typedef struct packed {
        logic       core;
        logic [1:0] dma;
        logic [3:0] play;
    } t_cfg;

    typedef struct packed {
        logic               we;
        logic               bank;
        logic [BANK_AW-1:0] idx;
        logic [15:0]        data;
    } t_wr_req;

    typedef struct packed {
        logic               re;
        logic [BANK_AW-1:0] even_l;
        logic [BANK_AW-1:0] odd_l;
        logic [BANK_AW-1:0] even_r;
        logic [BANK_AW-1:0] odd_r;
    } t_rd_req;

    typedef struct packed {
        logic enabled;
        logic pair;
        logic cdda;
        logic mute;
        logic left_odd;
        logic right_odd;
    } t_tick_ctl;

    typedef struct packed {
        logic        busy;
        logic [1:0]  free;
        logic [10:0] addr;
    } t_status;

endpackage

>>> rtl/aadir_in_if.sv
`timescale 1ns / 1ps
interface aadir_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [9:0]         buffer_index;
    logic signed [15:0] buffer_value;
    logic [19:0]        data_left;
    logic [8:0]         write_position;

    modport source (
        output valid, mode, buffer_index, buffer_value, data_left, write_position,
        input  ready
    );
    modport sink (
        input  valid, mode, buffer_index, buffer_value, data_left, write_position,
        output ready
    );
endinterface

>>> rtl/aadir_out_if.sv
`timescale 1ns / 1ps
interface aadir_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_sample;
    logic signed [31:0] right_sample;
    logic               in_progress;
    logic [1:0]         free_blocks;
    logic [10:0]        transfer_address;

    modport source (
        output valid, left_sample, right_sample, in_progress, free_blocks, transfer_address,
        input  ready
    );
    modport sink (
        input  valid, left_sample, right_sample, in_progress, free_blocks, transfer_address,
        output ready
    );
endinterface

>>> rtl/aadir_bank.sv
`timescale 1ns / 1ps
module aadir_bank
    import aadir_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [BANK_AW-1:0] i_waddr,
    input  logic [15:0]        i_wdata,
    input  logic               i_re,
    input  logic [BANK_AW-1:0] i_raddr_l,
    input  logic [BANK_AW-1:0] i_raddr_r,
    output logic [15:0]        o_rdata_l,
    output logic [15:0]        o_rdata_r
);

    logic [15:0] r_mem [BANK_DEPTH];
    logic [15:0] r_rdata_l;
    logic [15:0] r_rdata_r;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_l <= r_mem[i_raddr_l];
            r_rdata_r <= r_mem[i_raddr_r];
        end
    end

    assign o_rdata_l = r_rdata_l;
    assign o_rdata_r = r_rdata_r;

endmodule

>>> rtl/aadir_ctrl.sv
`timescale 1ns / 1ps
module aadir_ctrl
    import aadir_pkg::*;
#(
    parameter int HALF_WORDS = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_item     i_item,
    input  t_cfg      i_cfg,
    output t_wr_req   o_wr,
    output t_rd_req   o_rd,
    output t_tick_ctl o_ctl,
    output t_status   o_status
);

    localparam logic [10:0] L_HALF    = 11'(HALF_WORDS);
    localparam logic [10:0] L_QUARTER = 11'(HALF_WORDS / 2);

    logic [9:0]  r_rp;
    logic [1:0]  r_fc;
    logic        r_busy;
    logic [10:0] r_sa;

    logic [9:0]  n_rp;
    logic [1:0]  n_fc;
    logic        n_busy;
    logic [10:0] n_sa;

    logic        is_tick;
    logic        enabled;
    logic        cdda;
    logic        wide;
    logic        pair;
    logic        mute;
    logic [9:0]  pos;
    logic [9:0]  rpos;
    logic [9:0]  lpos1;
    logic [9:0]  rpos1;
    logic [10:0] np;
    logic [10:0] jp;
    logic        bnd;
    logic [2:0]  fsum;

    always_comb begin
        is_tick = (i_item.mode == MODE_TICK);
        enabled = i_cfg.dma[i_cfg.core];
        cdda    = i_cfg.core && i_cfg.play[PM_CDDA1];
        wide    = !cdda && !i_cfg.core && i_cfg.play[PM_WIDE0];
        pair    = cdda || wide;
        mute    = i_cfg.core && i_cfg.play[PM_MUTE1] && !pair;

        pos   = pair ? {r_rp[9:1], 1'b0} : r_rp;
        rpos  = pos + 10'(HALF_WORDS);
        lpos1 = pos + 10'd1;
        rpos1 = rpos + 10'd1;

        np  = {1'b0, pos} + (pair ? 11'd2 : 11'd1);
        bnd = wide ? (np >= L_HALF) : ((np == L_QUARTER) || (np >= L_HALF));

        jp     = np;
        fsum   = {1'b0, r_fc};
        n_fc   = r_fc;
        n_busy = r_busy;
        n_sa   = r_sa;
        if (bnd) begin
            n_busy = 1'b0;
            if (i_item.data_left >= 20'(HALF_WORDS)) begin
                fsum = {1'b0, r_fc} + (pair ? 3'd2 : 3'd1);
                if (fsum > 3'd2) begin
                    fsum = 3'd2;
                    jp   = {2'b00, i_item.write_position};
                end
                n_fc   = fsum[1:0];
                n_busy = 1'b1;
                n_sa   = {i_cfg.core, jp[9:0]};
            end
            if (jp >= L_HALF) begin
                jp = jp - L_HALF;
            end
        end
        n_rp = jp[9:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_fc   <= '0;
            r_busy <= 1'b0;
            r_sa   <= '0;
        end else if (i_fire) begin
            case (i_item.mode)
                MODE_TICK: begin
                    if (enabled) begin
                        r_rp   <= n_rp;
                        r_fc   <= n_fc;
                        r_busy <= n_busy;
                        r_sa   <= n_sa;
                    end
                end
                MODE_CLAIM: begin
                    if (r_fc != 2'd0) begin
                        r_fc <= r_fc - 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // write port, word index split into bank and row
    assign o_wr.we   = i_fire && (i_item.mode == MODE_WRITE);
    assign o_wr.bank = i_item.buffer_index[0];
    assign o_wr.idx  = i_item.buffer_index[STORE_AW-1:1];
    assign o_wr.data = i_item.buffer_value;

    // low word sits in bank pos[0], the following word in the other bank
    assign o_rd.re     = i_fire && is_tick;
    assign o_rd.even_l = lpos1[STORE_AW-1:1];
    assign o_rd.odd_l  = pos[STORE_AW-1:1];
    assign o_rd.even_r = rpos1[STORE_AW-1:1];
    assign o_rd.odd_r  = rpos[STORE_AW-1:1];

    assign o_ctl.enabled   = enabled;
    assign o_ctl.pair      = pair;
    assign o_ctl.cdda      = cdda;
    assign o_ctl.mute      = mute;
    assign o_ctl.left_odd  = pos[0];
    assign o_ctl.right_odd = rpos[0];

    assign o_status.busy = enabled ? n_busy : r_busy;
    assign o_status.free = enabled ? n_fc : r_fc;
    assign o_status.addr = enabled ? n_sa : r_sa;

endmodule

>>> rtl/aadir_fmt.sv
`timescale 1ns / 1ps
module aadir_fmt
    import aadir_pkg::*;
(
    input  t_tick_ctl          i_ctl,
    input  logic [15:0]        i_even_l,
    input  logic [15:0]        i_odd_l,
    input  logic [15:0]        i_even_r,
    input  logic [15:0]        i_odd_r,
    output logic signed [31:0] o_left,
    output logic signed [31:0] o_right
);

    function automatic logic signed [31:0] f_sample(
        input logic [15:0] lo,
        input logic [15:0] hi,
        input t_tick_ctl   c
    );
        logic signed [31:0] w;
        w = signed'({hi, lo});
        if (!c.enabled || c.mute) begin
            return '0;
        end
        if (c.cdda) begin
            return w >>> 2;
        end
        if (c.pair) begin
            return w;
        end
        return 32'(signed'(lo));
    endfunction

    logic [15:0] lo_l;
    logic [15:0] hi_l;
    logic [15:0] lo_r;
    logic [15:0] hi_r;

    always_comb begin
        lo_l = i_ctl.left_odd ? i_odd_l : i_even_l;
        hi_l = i_ctl.left_odd ? i_even_l : i_odd_l;
        lo_r = i_ctl.right_odd ? i_odd_r : i_even_r;
        hi_r = i_ctl.right_odd ? i_even_r : i_odd_r;
    end

    assign o_left  = f_sample(lo_l, hi_l, i_ctl);
    assign o_right = f_sample(lo_r, hi_r, i_ctl);

endmodule

>>> rtl/audio_auto_dma_input_reader_core.sv
`timescale 1ns / 1ps
// channel   dir  kind             transfer
// i_in      in   item             valid && ready
// o_out     out  stereo result    valid && ready
// i_cfg_*   in   register write   i_cfg_we
//
// one item per cycle sustained while o_out is not stalled; a tick's result passes through
// the input register, then the sample memory read register and the output register
// sample memory is two 512-word banks (even and odd words), each read at two rows a cycle
// synchronous reset clears pipeline valids, config and read/free/busy/address state;
// memory contents are undefined until written, no clearing pass
// i_in.ready drops only when all three stages hold items and o_out is stalled
module audio_auto_dma_input_reader_core
    import aadir_pkg::*;
#(
    parameter int HALF_WORDS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aadir_in_if.sink    i_in,
    aadir_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_a_valid;
    t_item     r_a_item;
    logic      r_b_valid;
    t_tick_ctl r_b_ctl;
    t_status   r_b_status;
    logic      r_o_valid;
    logic signed [31:0] r_o_left;
    logic signed [31:0] r_o_right;
    t_status   r_o_status;

    logic      en_o;
    logic      en_b;
    logic      en_a;
    logic      fire;
    logic      a_tick;
    t_wr_req   wr;
    t_rd_req   rd;
    t_tick_ctl a_ctl;
    t_status   a_status;
    logic [15:0] even_l;
    logic [15:0] even_r;
    logic [15:0] odd_l;
    logic [15:0] odd_r;
    logic signed [31:0] fmt_left;
    logic signed [31:0] fmt_right;

    assign en_o   = !r_o_valid || o_out.ready;
    assign en_b   = !r_b_valid || en_o;
    assign en_a   = !r_a_valid || en_b;
    assign fire   = r_a_valid && en_b;
    assign a_tick = fire && (r_a_item.mode == MODE_TICK);
    assign i_in.ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CORE_SELECT: begin
                    r_cfg.core <= i_cfg_data[0];
                end
                CFG_DMA_ENABLE: begin
                    r_cfg.dma <= i_cfg_data[1:0];
                end
                CFG_PLAY_MODE: begin
                    r_cfg.play <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_in.valid;
            end
            if (en_b) begin
                r_b_valid <= a_tick;
            end
            if (en_o) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_in.valid) begin
            r_a_item.mode           <= i_in.mode;
            r_a_item.buffer_index   <= i_in.buffer_index;
            r_a_item.buffer_value   <= i_in.buffer_value;
            r_a_item.data_left      <= i_in.data_left;
            r_a_item.write_position <= i_in.write_position;
        end
        if (a_tick) begin
            r_b_ctl    <= a_ctl;
            r_b_status <= a_status;
        end
        if (en_o && r_b_valid) begin
            r_o_left   <= fmt_left;
            r_o_right  <= fmt_right;
            r_o_status <= r_b_status;
        end
    end

    aadir_ctrl #(
        .HALF_WORDS (HALF_WORDS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_a_item),
        .i_cfg    (r_cfg),
        .o_wr     (wr),
        .o_rd     (rd),
        .o_ctl    (a_ctl),
        .o_status (a_status)
    );

    aadir_bank u_bank_even (
        .i_clk     (i_clk),
        .i_we      (wr.we && !wr.bank),
        .i_waddr   (wr.idx),
        .i_wdata   (wr.data),
        .i_re      (rd.re),
        .i_raddr_l (rd.even_l),
        .i_raddr_r (rd.even_r),
        .o_rdata_l (even_l),
        .o_rdata_r (even_r)
    );

    aadir_bank u_bank_odd (
        .i_clk     (i_clk),
        .i_we      (wr.we && wr.bank),
        .i_waddr   (wr.idx),
        .i_wdata   (wr.data),
        .i_re      (rd.re),
        .i_raddr_l (rd.odd_l),
        .i_raddr_r (rd.odd_r),
        .o_rdata_l (odd_l),
        .o_rdata_r (odd_r)
    );

    aadir_fmt u_fmt (
        .i_ctl    (r_b_ctl),
        .i_even_l (even_l),
        .i_odd_l  (odd_l),
        .i_even_r (even_r),
        .i_odd_r  (odd_r),
        .o_left   (fmt_left),
        .o_right  (fmt_right)
    );

    assign o_out.valid            = r_o_valid;
    assign o_out.left_sample      = r_o_left;
    assign o_out.right_sample     = r_o_right;
    assign o_out.in_progress      = r_o_status.busy;
    assign o_out.free_blocks      = r_o_status.free;
    assign o_out.transfer_address = r_o_status.addr;

endmodule

>>> rtl/aadir_chk.sv
`timescale 1ns / 1ps
`include "audio_auto_dma_input_reader_core_defines.svh"
module aadir_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_left,
    input logic signed [31:0] i_right,
    input logic               i_in_progress,
    input logic [1:0]         i_free_blocks,
    input logic [10:0]        i_transfer_address
);

    logic        out_stall;
    logic        in_idle;
    logic [77:0] out_word;

    assign out_stall = i_rst_n && i_out_valid && !i_out_ready;
    assign in_idle   = !i_in_valid;
    assign out_word  = {i_left, i_right, i_in_progress, i_free_blocks, i_transfer_address};

    `AADIR_ASSERT_NEXT(a_reset_clears_out, !i_rst_n, !i_out_valid)
    `AADIR_ASSERT_NEXT(a_reset_opens_in, !i_rst_n, i_in_ready)
    `AADIR_ASSERT_NEXT(a_stall_keeps_valid, out_stall, i_out_valid)
    `AADIR_ASSERT_NEXT(a_stall_keeps_data, out_stall, $stable(out_word))
    `AADIR_ASSERT_SAME(a_free_in_range, i_out_valid || in_idle, !i_out_valid || (i_free_blocks != 2'd3))

endmodule

bind audio_auto_dma_input_reader_core aadir_chk u_aadir_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_left             (o_out.left_sample),
    .i_right            (o_out.right_sample),
    .i_in_progress      (o_out.in_progress),
    .i_free_blocks      (o_out.free_blocks),
    .i_transfer_address (o_out.transfer_address)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import aadir_pkg::*;

    localparam int HALF = 512;
    localparam int STORE_WORDS = 1024;
    localparam int LATENCY = 3;
    localparam int TOTAL_ITEMS = 400;
    localparam int NUM_PHASES = 10;
    localparam int MIN_PHASE_ITEMS = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [1:0] MODE_NOISE = 2'd3;

    typedef struct {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic               busy;
        logic [1:0]         free;
        logic [10:0]        addr;
    } t_stereo;

    class reader_scoreboard;
        logic [15:0] words [STORE_WORDS];
        logic [9:0]  rd_pos;
        logic [1:0]  free_cnt;
        logic        busy;
        logic [10:0] start_addr;
        logic        core;
        logic [1:0]  dma;
        logic [3:0]  play;
        int unsigned blocks_seen;
        int unsigned n_errors;
        t_stereo     due_samples[$];

        function new();
            foreach (words[i]) words[i] = '0;
            rd_pos = '0;
            free_cnt = '0;
            busy = 1'b0;
            start_addr = '0;
            core = 1'b0;
            dma = '0;
            play = '0;
            blocks_seen = 0;
            n_errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [3:0] d);
            case (idx)
                CFG_CORE_SELECT: core = d[0];
                CFG_DMA_ENABLE:  dma = d[1:0];
                CFG_PLAY_MODE:   play = d;
                default: ;
            endcase
        endfunction

        function int pending();
            return due_samples.size();
        endfunction

        // a tick on an enabled core reads sample words unless it is muted
        function bit reads_words();
            logic pair;
            pair = core ? play[PM_CDDA1] : play[PM_WIDE0];
            return dma[core] && (pair || !core || !play[PM_MUTE1]);
        endfunction

        function t_stereo play_tick(logic [19:0] dleft, logic [8:0] wpos);
            t_stereo r;
            int unsigned pos;
            int unsigned step;
            int unsigned f;
            logic cdda;
            logic wide;
            logic mute;
            logic at_block;
            logic [31:0] lw;
            logic [31:0] rw;
            r.left = '0;
            r.right = '0;
            if (dma[core]) begin
                cdda = core && play[PM_CDDA1];
                wide = !cdda && !core && play[PM_WIDE0];
                mute = core && play[PM_MUTE1];
                pos = rd_pos;
                step = 1;
                if (cdda || wide) begin
                    pos = pos & ~32'd1;
                    lw = {words[(pos + 1) % STORE_WORDS], words[pos % STORE_WORDS]};
                    rw = {words[(pos + HALF + 1) % STORE_WORDS],
                          words[(pos + HALF) % STORE_WORDS]};
                    if (cdda) begin
                        lw = $signed(lw) >>> 2;
                        rw = $signed(rw) >>> 2;
                    end
                    r.left = lw;
                    r.right = rw;
                    step = 2;
                end else if (!mute) begin
                    r.left = $signed(words[pos % STORE_WORDS]);
                    r.right = $signed(words[(pos + HALF) % STORE_WORDS]);
                end
                pos = pos + step;
                at_block = wide ? (pos >= HALF) : (pos == HALF / 2 || pos >= HALF);
                if (at_block) begin
                    blocks_seen++;
                    busy = 1'b0;
                    if (dleft >= HALF) begin
                        f = free_cnt + step;
                        if (f > 2) begin
                            f = 2;
                            pos = wpos;
                        end
                        free_cnt = 2'(f);
                        busy = 1'b1;
                        start_addr = 11'((core ? 1024 : 0) + pos);
                    end
                    if (pos >= HALF) pos = pos - HALF;
                end
                rd_pos = 10'(pos % STORE_WORDS);
            end
            r.busy = busy;
            r.free = free_cnt;
            r.addr = start_addr;
            return r;
        endfunction

        function void note_item(t_item it);
            case (it.mode)
                MODE_WRITE: words[it.buffer_index] = it.buffer_value;
                MODE_CLAIM: if (free_cnt != 0) free_cnt = free_cnt - 2'd1;
                MODE_TICK:  due_samples.push_back(play_tick(it.data_left, it.write_position));
                default: ;
            endcase
        endfunction

        function void check_result(t_stereo got);
            t_stereo want;
            if (due_samples.size() == 0) begin
                $error("result with no tick pending");
                n_errors++;
                return;
            end
            want = due_samples.pop_front();
            if (got.left !== want.left) begin
                $error("left_sample: expected %0d, actual %0d", want.left, got.left);
                n_errors++;
            end
            if (got.right !== want.right) begin
                $error("right_sample: expected %0d, actual %0d", want.right, got.right);
                n_errors++;
            end
            if (got.busy !== want.busy) begin
                $error("in_progress: expected %0d, actual %0d", want.busy, got.busy);
                n_errors++;
            end
            if (got.free !== want.free) begin
                $error("free_blocks: expected %0d, actual %0d", want.free, got.free);
                n_errors++;
            end
            if (got.addr !== want.addr) begin
                $error("transfer_address: expected %0d, actual %0d", want.addr, got.addr);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [1:0] cfg_idx;
    logic [3:0] cfg_data;
    logic calm;
    bit written [STORE_WORDS];
    int unsigned idle_cycles = 0;
    int unsigned n_sent = 0;
    t_stereo seen;
    reader_scoreboard sb;

    aadir_in_if  in_ch ();
    aadir_out_if out_ch ();

    audio_auto_dma_input_reader_core #(
        .HALF_WORDS(HALF)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [19:0] rand_left();
        case ($urandom_range(0, 5))
            0: return 20'd0;
            1: return 20'd511;
            2: return 20'd512;
            3: return 20'hfffff;
            4: return 20'($urandom);
            default: return 20'($urandom_range(512, 4095));
        endcase
    endfunction

    function automatic logic [8:0] rand_wpos();
        case ($urandom_range(0, 5))
            0: return 9'd0;
            1: return 9'd511;
            2: return 9'($urandom_range(244, 255));
            3: return 9'($urandom_range(500, 511));
            default: return 9'($urandom);
        endcase
    endfunction

    function automatic t_item rand_item(logic [1:0] mode);
        t_item it;
        it.mode = mode;
        it.buffer_index = 10'($urandom);
        it.buffer_value = 16'($urandom);
        it.data_left = 20'($urandom);
        it.write_position = 9'($urandom);
        return it;
    endfunction

    task automatic push_item(input t_item it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= it.mode;
        in_ch.buffer_index <= it.buffer_index;
        in_ch.buffer_value <= it.buffer_value;
        in_ch.data_left <= it.data_left;
        in_ch.write_position <= it.write_position;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_item(it);
        n_sent++;
        if (it.mode == MODE_WRITE) written[it.buffer_index] = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic send_write(input logic [9:0] idx, input logic [15:0] value);
        t_item it;
        it = rand_item(MODE_WRITE);
        it.buffer_index = idx;
        it.buffer_value = value;
        push_item(it);
    endtask

    // make sure every word the next tick may touch holds data
    task automatic send_tick(input logic [19:0] dleft, input logic [8:0] wpos);
        t_item it;
        int unsigned base;
        int unsigned idx;
        if (sb.reads_words()) begin
            base = sb.rd_pos & ~10'd1;
            for (int k = 0; k < 4; k++) begin
                idx = (base + (k % 2) + (k / 2) * HALF) % STORE_WORDS;
                if (!written[idx]) send_write(10'(idx), rand_word());
            end
        end
        it = rand_item(MODE_TICK);
        it.data_left = dleft;
        it.write_position = wpos;
        push_item(it);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] d);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        sb.set_reg(idx, d);
        @(negedge i_clk);
    endtask

    task automatic set_cfg(input t_cfg c);
        logic [3:0] d;
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
        d = 4'($urandom_range(0, 15));
        d[0] = c.core;
        write_reg(CFG_CORE_SELECT, d);
        d = 4'($urandom_range(0, 15));
        d[1:0] = c.dma;
        write_reg(CFG_DMA_ENABLE, d);
        write_reg(CFG_PLAY_MODE, c.play);
        cfg_we <= 1'b0;
    endtask

    // every transfer counts against the budget, sample word fills too
    task automatic run_phase(input int unsigned n_items);
        int unsigned stop;
        int sel;
        stop = n_sent + n_items;
        while (n_sent < stop) begin
            sel = $urandom_range(0, 99);
            if (sel < 78) begin
                send_tick(rand_left(), rand_wpos());
            end else if (sel < 88) begin
                push_item(rand_item(MODE_CLAIM));
            end else if (sel < 96) begin
                send_write(10'($urandom), rand_word());
            end else begin
                push_item(rand_item(MODE_NOISE));
            end
        end
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            int stall_left;
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            seen.left = out_ch.left_sample;
            seen.right = out_ch.right_sample;
            seen.busy = out_ch.in_progress;
            seen.free = out_ch.free_blocks;
            seen.addr = out_ch.transfer_address;
            sb.check_result(seen);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_item it;
        t_cfg c;
        int unsigned per_phase;
        sb = new();
        calm = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_TICK;
        in_ch.buffer_index = '0;
        in_ch.buffer_value = '0;
        in_ch.data_left = '0;
        in_ch.write_position = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes and each read form
        set_cfg('{core: 1'b0, dma: 2'b01, play: 4'h0});
        send_write(10'd0, 16'h8000);
        send_write(10'd512, 16'h7fff);
        send_write(10'd1023, 16'hffff);
        send_write(10'd1, 16'h7fff);
        send_write(10'd513, 16'h8000);
        send_write(10'd511, 16'h0001);
        push_item(rand_item(MODE_CLAIM));
        it = rand_item(MODE_NOISE);
        it.buffer_index = '1;
        it.buffer_value = '1;
        it.data_left = '1;
        it.write_position = '1;
        push_item(it);
        send_tick(20'd0, 9'd0);
        send_tick(20'hfffff, 9'd511);
        send_tick(20'd512, 9'd255);
        // odd position on a 32-bit read
        set_cfg('{core: 1'b0, dma: 2'b01, play: 4'h4});
        send_tick(20'd511, 9'd1);
        set_cfg('{core: 1'b1, dma: 2'b10, play: 4'h8});
        send_tick(20'hfffff, 9'd0);
        set_cfg('{core: 1'b1, dma: 2'b11, play: 4'h2});
        send_tick(20'd0, 9'd511);
        set_cfg('{core: 1'b1, dma: 2'b01, play: 4'hf});
        send_tick(20'hfffff, 9'd511);

        // muted ticks until the first block boundary, no sample words needed
        set_cfg('{core: 1'b1, dma: 2'b11, play: 4'h2});
        while (sb.blocks_seen == 0) send_tick(rand_left(), rand_wpos());

        if (n_sent + NUM_PHASES * MIN_PHASE_ITEMS < TOTAL_ITEMS) begin
            per_phase = (TOTAL_ITEMS - n_sent) / NUM_PHASES;
        end else begin
            per_phase = MIN_PHASE_ITEMS;
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: c = '{core: 1'b0, dma: 2'b11, play: 4'h4};
                1: c = '{core: 1'b1, dma: 2'b10, play: 4'h8};
                2: c = '{core: 1'b0, dma: 2'b01, play: 4'h0};
                3: c = '{core: 1'b1, dma: 2'b11, play: 4'h2};
                4: c = '{core: 1'b0, dma: 2'b00, play: 4'hf};
                default: begin
                    c.core = 1'($urandom_range(0, 1));
                    c.dma = 2'($urandom_range(0, 3));
                    c.play = 4'($urandom_range(0, 15));
                    c.dma[c.core] = ($urandom_range(0, 4) != 0);
                end
            endcase
            calm = (p == NUM_PHASES - 1) || ($urandom_range(0, 4) == 0);
            set_cfg(c);
            run_phase(per_phase);
        end

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        if (sb.n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
